[rtl/core/ptbr_pkg.sv]
// Shared types and constants of the pulse timing byte receiver.
`timescale 1ns / 1ps

package ptbr_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_GAP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_GAP   = 2'd2;

  localparam int unsigned GapW = 20;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CharW = 7;

  // Reset values of the gap registers
  localparam logic [GapW-1:0] SHORT_GAP_RST = 20'd2500;
  localparam logic [GapW-1:0] END_GAP_RST   = 20'd80000;

  // Decoding modes
  localparam logic MODE_TWO_SIGNAL = 1'b0;
  localparam logic MODE_ONE_SIGNAL = 1'b1;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [GapW-1:0] short_gap;
    logic [GapW-1:0] end_gap;
  } cfg_t;

  typedef struct packed {
    logic             pulse_kind;
    logic [TimeW-1:0] now_us;
  } pulse_t;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] char_code;
    logic             ok;
  } result_t;

endpackage

[rtl/core/ptbr_in_stage.sv]
// Input register stage holding one pulse word ahead of the decoder.
`timescale 1ns / 1ps

module ptbr_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  ptbr_pkg::pulse_t item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output ptbr_pkg::pulse_t item_o
);

  logic            valid_q, valid_d;
  ptbr_pkg::pulse_t item_q;

  // Take a new word whenever the held one leaves or none is held
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  ap_adv_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |-> valid_q)
    else $error("advance without a held word");

endmodule

[rtl/core/ptbr_decode.sv]
// Bit decoder: message state and the per-pulse decode step.
`timescale 1ns / 1ps

module ptbr_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ptbr_pkg::pulse_t  item_i,
  input  ptbr_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output ptbr_pkg::result_t res_o
);

  logic                       started_q, started_d;
  logic [ptbr_pkg::TimeW-1:0] last_q, last_d;
  logic [8:0]                 shift_q, shift_d;
  logic [3:0]                 count_q, count_d;
  logic                       err_q, err_d;

  logic [ptbr_pkg::TimeW-1:0] diff;
  logic [ptbr_pkg::TimeW-1:0] short_ext, end_ext;
  logic [8:0]                 shift_n;
  logic [3:0]                 count_n;
  logic [7:0]                 byte_v;
  logic                       byte_full;
  logic                       finish;

  assign short_ext = {{(ptbr_pkg::TimeW-ptbr_pkg::GapW){1'b0}}, cfg_i.short_gap};
  assign end_ext   = {{(ptbr_pkg::TimeW-ptbr_pkg::GapW){1'b0}}, cfg_i.end_gap};

  // Gap since the last timed pulse; zero for the first pulse of a message
  assign diff = started_q ? (item_i.now_us - last_q) : '0;

  // Decode one pulse
  always_comb begin
    started_d = started_q;
    last_d    = last_q;
    shift_d   = shift_q;
    count_d   = count_q;
    err_d     = err_q;
    shift_n   = shift_q;
    count_n   = count_q + 4'd1;
    byte_v    = '0;
    byte_full = 1'b0;
    finish    = 1'b0;

    if (cfg_i.mode == ptbr_pkg::MODE_TWO_SIGNAL) begin
      if (!item_i.pulse_kind && diff > end_ext) begin
        finish = 1'b1;
      end else begin
        shift_n   = {shift_q[7:0], ~item_i.pulse_kind};
        started_d = 1'b1;
        last_d    = item_i.now_us;
        if (count_n[3]) begin
          byte_full = 1'b1;
          byte_v    = shift_n[7:0];
          count_d   = count_n - 4'd8;
          shift_d   = '0;
        end else begin
          count_d = count_n;
          shift_d = shift_n;
        end
      end
    end else begin
      if (!started_q) begin
        started_d = 1'b1;
        last_d    = item_i.now_us;
        shift_d   = 9'd1;
      end else if (diff < short_ext) begin
        // Second pulse inside the short gap: pending bit becomes a zero
        shift_d = {shift_q[8:1], 1'b0};
      end else if (diff > end_ext) begin
        finish = 1'b1;
      end else begin
        shift_n = {shift_q[7:0], 1'b1};
        last_d  = item_i.now_us;
        if (count_n[3]) begin
          byte_full = 1'b1;
          byte_v    = shift_n[8:1];
          count_d   = count_n - 4'd8;
          shift_d   = {8'd0, shift_n[0]};
        end else begin
          count_d = count_n;
          shift_d = shift_n;
        end
      end
    end

    // Drop all-ones bytes, flag bytes with the top bit set
    if (byte_full && byte_v != 8'hFF && byte_v[7]) begin
      err_d = 1'b1;
    end

    if (finish) begin
      started_d = 1'b0;
      last_d    = '0;
      shift_d   = '0;
      count_d   = '0;
      err_d     = 1'b0;
    end
  end

  // Form the result word
  always_comb begin
    res_valid_o     = 1'b0;
    res_o.kind      = ptbr_pkg::KIND_CHAR;
    res_o.char_code = byte_v[6:0];
    res_o.ok        = 1'b0;
    if (finish) begin
      res_valid_o     = 1'b1;
      res_o.kind      = ptbr_pkg::KIND_END;
      res_o.char_code = '0;
      res_o.ok        = !err_q && (count_q == 4'd0);
    end else if (byte_full && !byte_v[7]) begin
      res_valid_o = 1'b1;
    end
  end

  // Advance message state on each decoded pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      last_q    <= '0;
      shift_q   <= '0;
      count_q   <= '0;
      err_q     <= 1'b0;
    end else if (fire_i) begin
      started_q <= started_d;
      last_q    <= last_d;
      shift_q   <= shift_d;
      count_q   <= count_d;
      err_q     <= err_d;
    end
  end

  ap_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < 4'd8)
    else $error("bit count left a full byte unformed");

  ap_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.kind == ptbr_pkg::KIND_END
      |=> !started_q && !err_q && count_q == 4'd0)
    else $error("message state not cleared after end");

endmodule

[rtl/core/pulse_timing_byte_receiver_top.sv]
// Top level of the pulse timing byte receiver: config registers and result register.
//
//   channel  | dir | handshake                 | payload
//   s_axis   | in  | s_axis_tvalid_i/tready_o  | tuser: pulse_kind; tdata: now_us
//   m_axis   | out | m_axis_tvalid_o/tready_i  | tuser: kind; tdata: char_code, ok
//   cfg      | in  | cfg_we_i (no stall)       | cfg_idx_i, cfg_wdata_i
//
// One pulse word per cycle is sustained while m_axis_tready_i holds high; a word waits in the
// input register, and its result, if any, is then written into the result register.
// The decode step between them is combinational: one 32-bit subtract and two compares.
// rst_ni clears the message state and loads the gap registers with their defaults.
// A stalled result register holds the input stage; s_axis_tready_o falls only
// when both stages hold words.
`timescale 1ns / 1ps

module pulse_timing_byte_receiver_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [31:0]                    s_axis_tdata_i,  // [31:0] now_us
  input  logic [0:0]                     s_axis_tuser_i,  // [0] pulse_kind
  // master side
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,  // [6:0] char_code, [7] ok
  output logic [0:0]                     m_axis_tuser_o,  // [0] kind
  // configuration
  input  logic                           cfg_we_i,
  input  logic [ptbr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ptbr_pkg::GapW-1:0]      cfg_wdata_i
);

  ptbr_pkg::cfg_t    cfg_q, cfg_d;
  ptbr_pkg::pulse_t  in_item, hold_item;
  ptbr_pkg::result_t res, out_q;
  logic              hold_valid, advance, res_valid;
  logic              out_valid_q, out_valid_d;

  // Write configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptbr_pkg::CFG_MODE:      cfg_d.mode      = cfg_wdata_i[0];
        ptbr_pkg::CFG_SHORT_GAP: cfg_d.short_gap = cfg_wdata_i;
        ptbr_pkg::CFG_END_GAP:   cfg_d.end_gap   = cfg_wdata_i;
        default:                 cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= ptbr_pkg::MODE_TWO_SIGNAL;
      cfg_q.short_gap <= ptbr_pkg::SHORT_GAP_RST;
      cfg_q.end_gap   <= ptbr_pkg::END_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.pulse_kind = s_axis_tuser_i[0];
  assign in_item.now_us     = s_axis_tdata_i;

  ptbr_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (hold_valid),
    .item_o    (hold_item)
  );

  // Decode the held word when the result register is free or draining
  assign advance = hold_valid && (!out_valid_q || m_axis_tready_i);

  ptbr_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (hold_item),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {out_q.ok, out_q.char_code};
  assign m_axis_tuser_o[0] = out_q.kind;

  ap_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !advance)
    else $error("decoder advanced into a stalled result register");

  ap_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |=> out_valid_q)
    else $error("decoded result lost");

endmodule
